// ===== hw/rtl/fba_pkg.sv =====
// shared types, constants and helpers of the frame bitmap allocator
`timescale 1ns / 1ps

package fba_pkg;

    // payload widths
    localparam int unsigned OPCODE_W = 1;
    localparam int unsigned BOUND_W  = 11;
    localparam int unsigned FRAME_W  = 10;

    // map word layout: first frame of a word in the top bit
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned WORD_LW = 4;

    localparam logic [OPCODE_W-1:0] OP_RANGE = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANGE,
        ST_ALLOC,
        ST_DONE
    } t_state;

    // position (0 = top bit) of the first set bit counted from the top
    function automatic logic [WORD_LW-1:0] first_set(input logic [WORD_W-1:0] word);
        logic [WORD_LW-1:0] pos;
        pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (word[WORD_W-1-j]) begin
                pos = WORD_LW'(j);
            end
        end
        return pos;
    endfunction

endpackage

// ===== hw/rtl/fba_in_if.sv =====
// request channel of the frame bitmap allocator
`timescale 1ns / 1ps

interface fba_in_if;
    logic                             valid;
    logic                             ready;
    logic [fba_pkg::OPCODE_W-1:0]     opcode;
    logic                             keep_others;
    logic [fba_pkg::BOUND_W-1:0]      first_frame;
    logic [fba_pkg::BOUND_W-1:0]      end_frame;

    modport source (output valid, opcode, keep_others, first_frame, end_frame, input ready);
    modport sink   (input valid, opcode, keep_others, first_frame, end_frame, output ready);
endinterface

// ===== hw/rtl/fba_out_if.sv =====
// result channel of the frame bitmap allocator
`timescale 1ns / 1ps

interface fba_out_if;
    logic                         valid;
    logic                         ready;
    logic [fba_pkg::FRAME_W-1:0]  frame_number;
    logic                         found;

    modport source (output valid, frame_number, found, input ready);
    modport sink   (input valid, frame_number, found, output ready);
endinterface

// ===== hw/rtl/frame_bitmap_allocator.sv =====
// frame_bitmap_allocator: first-fit bitmap allocator of physical memory frames
`timescale 1ns / 1ps

// The map holds one bit per frame (set = free) in a single-port-write,
// registered-read memory of FRAME_COUNT/16 (rounded up) sixteen-bit words,
// frame 16*w+j sitting in bit 15-j of word w. After reset no frame is free;
// a per-word valid flag makes a never-written word read as zero, so there is
// no clearing pass and requests are taken straight out of reset. One
// transaction is handled at a time. A range transaction reads, modifies and
// writes back every map word in a read/write pipeline. An allocate
// transaction scans words from the lowest one and stops at the first word
// with a free frame. The memory read port delivers one word per cycle. The
// result sits in an output register, so a new request is accepted while a
// result still waits; a finished transaction only stalls if the previous
// result has not been taken. Range results carry frame_number 0 and found 0;
// a failed allocation also reports 0 / 0 and leaves the map untouched. Frame
// numbers wider than 10 bits are reported by their low 10 bits.
module frame_bitmap_allocator #(
    parameter int unsigned FRAME_COUNT = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fba_in_if.sink     i_in,
    fba_out_if.source  o_out
);

    // geometry
    localparam int unsigned WORDS   = (FRAME_COUNT + fba_pkg::WORD_W - 1) / fba_pkg::WORD_W;
    localparam int unsigned WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned CNT_W   = $clog2(WORDS + 1);
    localparam int unsigned FIDX_W  = WADDR_W + fba_pkg::WORD_LW;
    // compare width: holds frame index, range bounds and FRAME_COUNT itself
    localparam int unsigned CMP_W   = ((FIDX_W > fba_pkg::BOUND_W) ? FIDX_W : fba_pkg::BOUND_W) + 2;

    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
    localparam logic [CMP_W-1:0]   FRAME_LIM = CMP_W'(FRAME_COUNT);

    // map memory and per-word written flags
    logic [fba_pkg::WORD_W-1:0] mem [WORDS];
    logic [WORDS-1:0]           r_wvalid;

    // control
    fba_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_p_live, n_p_live;
    logic [WADDR_W-1:0] r_p_addr, n_p_addr;

    // captured request
    logic                       r_keep, n_keep;
    logic [fba_pkg::BOUND_W-1:0] r_first, n_first;
    logic [fba_pkg::BOUND_W-1:0] r_end, n_end;

    // read data of the word in the modify stage
    logic [fba_pkg::WORD_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    // pending and delivered result
    logic [fba_pkg::FRAME_W-1:0] r_pend_frame, n_pend_frame;
    logic                        r_pend_found, n_pend_found;
    logic                        r_out_valid, n_out_valid;
    logic [fba_pkg::FRAME_W-1:0] r_out_frame, n_out_frame;
    logic                        r_out_found, n_out_found;

    // memory port controls
    logic                       rd_en;
    logic [WADDR_W-1:0]         rd_addr;
    logic                       wr_en;
    logic [fba_pkg::WORD_W-1:0] wr_data;

    // modify-stage helpers
    logic [fba_pkg::WORD_W-1:0] cur_word;
    logic [fba_pkg::WORD_W-1:0] range_mask;
    logic [fba_pkg::WORD_LW-1:0] hit_pos;
    logic [CMP_W-1:0]           hit_frame;
    logic                       in_fire;

    // a new request is taken only while idle
    assign i_in.ready = (r_state == fba_pkg::ST_IDLE);
    assign in_fire  = i_in.valid && i_in.ready;
    assign rd_addr  = r_cnt[WADDR_W-1:0];
    assign cur_word = r_rd_vld ? r_rd_data : '0;
    assign hit_pos  = fba_pkg::first_set(cur_word);
    assign hit_frame = CMP_W'({r_p_addr, hit_pos});

    // frames of the word in the modify stage that the range marks free
    always_comb begin
        logic [CMP_W-1:0] f;
        range_mask = '0;
        for (int j = 0; j < fba_pkg::WORD_W; j++) begin
            f = CMP_W'({r_p_addr, fba_pkg::WORD_LW'(j)});
            range_mask[fba_pkg::WORD_W-1-j] = (f >= CMP_W'(r_first)) && (f < CMP_W'(r_end))
                                              && (f < FRAME_LIM);
        end
    end

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_p_live     = 1'b0;
        n_p_addr     = r_p_addr;
        n_keep       = r_keep;
        n_first      = r_first;
        n_end        = r_end;
        n_pend_frame = r_pend_frame;
        n_pend_found = r_pend_found;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_frame  = r_out_frame;
        n_out_found  = r_out_found;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_data      = '0;

        case (r_state)
            fba_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_keep  = i_in.keep_others;
                    n_first = i_in.first_frame;
                    n_end   = i_in.end_frame;
                    n_cnt   = '0;
                    n_pend_frame = '0;
                    n_pend_found = 1'b0;
                    n_state = (i_in.opcode == fba_pkg::OP_ALLOC) ? fba_pkg::ST_ALLOC
                                                                 : fba_pkg::ST_RANGE;
                end
            end
            fba_pkg::ST_RANGE, fba_pkg::ST_ALLOC: begin
                // issue stage: one word read per cycle
                if (r_cnt < CNT_W'(WORDS)) begin
                    rd_en    = 1'b1;
                    n_p_live = 1'b1;
                    n_p_addr = rd_addr;
                    n_cnt    = r_cnt + CNT_W'(1);
                end
                // modify and write-back stage
                if (r_p_live) begin
                    if (r_state == fba_pkg::ST_RANGE) begin
                        wr_en   = 1'b1;
                        wr_data = (r_keep ? cur_word : '0) | range_mask;
                        if (r_p_addr == LAST_WORD) begin
                            n_p_live = 1'b0;
                            n_state  = fba_pkg::ST_DONE;
                        end
                    end else if (cur_word != '0) begin
                        // lowest free frame found: take it and stop scanning
                        wr_en   = 1'b1;
                        wr_data = cur_word & ~(fba_pkg::WORD_W'(1) << (fba_pkg::WORD_W - 1 - hit_pos));
                        n_pend_frame = hit_frame[fba_pkg::FRAME_W-1:0];
                        n_pend_found = 1'b1;
                        n_p_live = 1'b0;
                        n_state  = fba_pkg::ST_DONE;
                    end else if (r_p_addr == LAST_WORD) begin
                        n_p_live = 1'b0;
                        n_state  = fba_pkg::ST_DONE;
                    end
                end
            end
            fba_pkg::ST_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_frame = r_pend_frame;
                    n_out_found = r_pend_found;
                    n_state     = fba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fba_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fba_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_p_live    <= 1'b0;
            r_out_valid <= 1'b0;
            r_wvalid    <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_p_live    <= n_p_live;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_wvalid[r_p_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p_addr     <= n_p_addr;
        r_keep       <= n_keep;
        r_first      <= n_first;
        r_end        <= n_end;
        r_pend_frame <= n_pend_frame;
        r_pend_found <= n_pend_found;
        r_out_frame  <= n_out_frame;
        r_out_found  <= n_out_found;
    end

    // map memory: write in the modify stage, registered read in the issue stage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_p_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // written flag travels with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (rd_en) begin
            r_rd_vld <= r_wvalid[rd_addr];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_number = r_out_frame;
    assign o_out.found        = r_out_found;

endmodule
